// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ssa_pkg.sv -----
// Package with types, codes and constants of the sectioned slot allocator.
package ssa_pkg;

  // Fixed field widths of the item and register formats.
  localparam int FUNC_W     = 2;
  localparam int SECTION_W  = 4;
  localparam int SLOT_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int SECTIONS_W = 5;
  localparam int SLOTS_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Default sizes of the state.
  localparam int DEF_MAX_SECTIONS = 16;
  localparam int DEF_MAX_SLOTS    = 256;

  // Register reset values.
  localparam logic [SECTIONS_W-1:0] SECTIONS_RST = 5'd16;
  localparam logic [SLOTS_W-1:0]    SLOTS_RST    = 9'd256;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC     = 2'd0,
    FN_FREE      = 2'd1,
    FN_RESET_ONE = 2'd2,
    FN_RESET_ALL = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTIONS_IN_USE   = 1'b0,
    CFG_SLOTS_PER_SECTION = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

  // Current register contents.
  typedef struct packed {
    logic [SECTIONS_W-1:0] sections_in_use;
    logic [SLOTS_W-1:0]    slots_per_section;
  } cfg_t;

endpackage

// ----- hw/rtl/sectioned_slot_allocator.sv -----
// Top level of the sectioned slot allocator: control, metadata and stack memories.
//
// Input beats on s_* carry one operation: allocate, free, reset one section or
// reset all. Each beat gives exactly one result beat on m_* with the slot and a
// status code. Two registers (active section count, slots per section) are
// written through the cfg_* channel, which is always ready.
// Per-section cursor and free count sit in a small metadata RAM, one word per
// section; the freed slots sit in a stack RAM of MAX_SLOTS entries per section.
// An operation reads the metadata in its accept cycle; in the execute state it
// decides, writes back and registers its result once the output register is
// free. An allocation that pops the free stack writes back in the execute state,
// reads the stack and registers the popped slot in a further pop state. A new
// beat is taken only in the idle state, after the last one's read-modify-write.
// When the receiver stalls, the result stays in the output register and one
// further beat is still accepted; that one waits until the output frees.
// Reset empties every section at once through per-section valid bits, so no
// clearing pass is needed; reset-all works the same way.
`include "assert_macros.svh"

module sectioned_slot_allocator import ssa_pkg::*; #(
  parameter int MAX_SECTIONS = DEF_MAX_SECTIONS,
  parameter int MAX_SLOTS    = DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: func[1:0], section[5:2], slot_index[13:6], zero fill[15:14]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tdata: slot[7:0], status[9:8], zero fill[15:10]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SEC_AW = MAX_SECTIONS > 1 ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int POS_W  = $clog2(MAX_SLOTS);
  localparam int STK_D  = MAX_SECTIONS * MAX_SLOTS;
  localparam int STK_AW = STK_D > 1 ? $clog2(STK_D) : 1;
  localparam int CMP_W  = CNT_W > SLOTS_W ? CNT_W : SLOTS_W;
  localparam int META_W = 2 * CNT_W;

  cfg_t   cfg;
  state_t state, state_next;

  // Captured operation.
  func_t                func_q;
  logic [SECTION_W-1:0] sec_q;
  logic [SLOT_W-1:0]    idx_q;

  // Memory ports.
  logic              meta_re, meta_we;
  logic [SEC_AW-1:0] meta_raddr, sec_idx;
  logic [META_W-1:0] meta_rdata, meta_wdata;
  logic              stk_re, stk_we;
  logic [STK_AW-1:0] stk_addr, stk_base;
  logic [SLOT_W-1:0] stk_rdata;

  // Per-section valid bits; an invalid section reads as empty.
  logic [MAX_SECTIONS-1:0] sec_valid;

  // Decision made in the execute cycle.
  logic             d_meta_we, d_push, d_pop, d_clr_one, d_clr_all;
  logic [CNT_W-1:0] d_cur, d_cnt;
  logic [SLOT_W-1:0] d_slot;
  status_t          d_status;

  logic [CNT_W-1:0] cur_rd, cnt_rd;
  logic [CMP_W-1:0] cap;
  logic             sec_ok, accept, out_free, commit, out_load;
  logic [SLOT_W-1:0] out_slot;
  status_t          out_status;

  ssa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssa_ram #(.WIDTH(META_W), .DEPTH(MAX_SECTIONS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (sec_idx),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  ssa_ram #(.WIDTH(SLOT_W), .DEPTH(STK_D)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_addr),
    .wdata (idx_q),
    .re    (stk_re),
    .raddr (stk_addr),
    .rdata (stk_rdata)
  );

  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign meta_raddr = SEC_AW'(s_tdata[FUNC_W +: SECTION_W]);
  assign sec_idx    = SEC_AW'(sec_q);

  // Capture the operation fields on an input beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func_t'(s_tdata[FUNC_W-1:0]);
      sec_q  <= s_tdata[FUNC_W +: SECTION_W];
      idx_q  <= s_tdata[FUNC_W+SECTION_W +: SLOT_W];
    end
  end

  // Effective limits and the metadata as seen through the valid bit.
  always_comb begin
    cap    = (CMP_W'(cfg.slots_per_section) < CMP_W'(MAX_SLOTS)) ?
             CMP_W'(cfg.slots_per_section) : CMP_W'(MAX_SLOTS);
    sec_ok = (CMP_W'(sec_q) < CMP_W'(cfg.sections_in_use)) &&
             (CMP_W'(sec_q) < CMP_W'(MAX_SECTIONS));
    cur_rd = sec_valid[sec_idx] ? meta_rdata[CNT_W-1:0] : '0;
    cnt_rd = sec_valid[sec_idx] ? meta_rdata[META_W-1:CNT_W] : '0;
  end

  // Operation decode: new metadata, stack access and result.
  always_comb begin
    d_meta_we = 1'b0;
    d_push    = 1'b0;
    d_pop     = 1'b0;
    d_clr_one = 1'b0;
    d_clr_all = 1'b0;
    d_cur     = cur_rd;
    d_cnt     = cnt_rd;
    d_slot    = '0;
    d_status  = ST_OK;
    case (func_q)
      FN_ALLOC: begin
        if (!sec_ok) begin
          d_status = ST_INVALID;
        end else if (CMP_W'(cur_rd) < cap) begin
          d_slot    = SLOT_W'(cur_rd);
          d_cur     = cur_rd + CNT_W'(1);
          d_meta_we = 1'b1;
        end else if (cnt_rd != '0) begin
          d_cnt     = cnt_rd - CNT_W'(1);
          d_pop     = 1'b1;
          d_meta_we = 1'b1;
        end else begin
          d_status = ST_FULL;
        end
      end
      FN_FREE: begin
        if (!sec_ok || CMP_W'(idx_q) >= cap) begin
          d_status = ST_INVALID;
        end else if (CMP_W'(cnt_rd) >= CMP_W'(MAX_SLOTS)) begin
          d_status = ST_OVERFLOW;
        end else begin
          d_cnt     = cnt_rd + CNT_W'(1);
          d_push    = 1'b1;
          d_meta_we = 1'b1;
        end
      end
      FN_RESET_ONE: begin
        if (!sec_ok) begin
          d_status = ST_INVALID;
        end else begin
          d_clr_one = 1'b1;
        end
      end
      FN_RESET_ALL: begin
        d_clr_all = 1'b1;
      end
      default: ;
    endcase
  end

  // Stack address: section base plus the top-of-stack position.
  assign stk_base = STK_AW'(sec_idx) * STK_AW'(MAX_SLOTS);
  assign stk_addr = stk_base + STK_AW'(d_pop ? POS_W'(d_cnt) : POS_W'(cnt_rd));
  assign meta_wdata = {d_cnt, d_cur};

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (d_pop) begin
          state_next = S_POP;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready = 1'b0;
    meta_re  = 1'b0;
    commit   = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        meta_re  = s_tvalid;
      end
      S_EXEC: begin
        commit   = d_pop || out_free;
        out_load = !d_pop && out_free;
      end
      S_POP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign meta_we = commit && d_meta_we;
  assign stk_we  = commit && d_push;
  assign stk_re  = commit && d_pop;

  // Valid bits: set on a metadata write, cleared by the reset operations.
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_valid <= '0;
    end else if (commit && d_clr_all) begin
      sec_valid <= '0;
    end else if (commit && d_clr_one) begin
      sec_valid[sec_idx] <= 1'b0;
    end else if (meta_we) begin
      sec_valid[sec_idx] <= 1'b1;
    end
  end

  // Output register; a popped slot comes straight from the stack RAM.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot   <= (state == S_POP) ? stk_rdata : d_slot;
      out_status <= (state == S_POP) ? ST_OK : d_status;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-SLOT_W-STATUS_W){1'b0}}, out_status, out_slot};

  // Checks on the sequencing and the stored metadata.
  `ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC,
               "accepted beat did not enter execute")
  `ASSERT_IMPL(a_push_pop_excl, clk, rst, stk_we, !stk_re,
               "stack push and pop in the same cycle")
  `ASSERT_IMPL(a_count_bound, clk, rst, meta_we,
               CMP_W'(meta_wdata[META_W-1:CNT_W]) <= CMP_W'(MAX_SLOTS),
               "free count written beyond the stack size")
  `ASSERT_NEXT(a_result_source, clk, rst, !m_tvalid,
               !m_tvalid || $past(state) != S_IDLE,
               "result raised without an operation in flight")

endmodule

// ----- hw/rtl/ssa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ssa_cfg.sv -----
// Configuration register file of the slot allocator.
module ssa_cfg import ssa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register update on each write beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sections_in_use   <= SECTIONS_RST;
      cfg.slots_per_section <= SLOTS_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SECTIONS_IN_USE:   cfg.sections_in_use   <= cfg_data[SECTIONS_W-1:0];
        CFG_SLOTS_PER_SECTION: cfg.slots_per_section <= cfg_data[SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- dv/sectioned_slot_allocator_test.sv -----
// Testbench for the sectioned slot allocator: directed and random operations with a predictor.
`timescale 1ns / 100ps

module sectioned_slot_allocator_test import ssa_pkg::*;;

  localparam int MAX_SECTIONS = DEF_MAX_SECTIONS;
  localparam int MAX_SLOTS    = DEF_MAX_SLOTS;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 200;
  localparam int NUM_PHASES   = 7;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } slot_result_t;

  // Tracks cursors, free stacks and registers, and holds the results still owed.
  class slot_scoreboard;
    logic [SECTIONS_W-1:0] sections_in_use;
    logic [SLOTS_W-1:0]    slots_per_section;
    logic [SLOTS_W-1:0]    cursor [MAX_SECTIONS];
    logic [SLOTS_W-1:0]    depth [MAX_SECTIONS];
    logic [SLOT_W-1:0]     freed [MAX_SECTIONS][MAX_SLOTS];
    slot_result_t          owed_results [$];
    int unsigned           errors;

    function new();
      sections_in_use   = SECTIONS_RST;
      slots_per_section = SLOTS_RST;
      foreach (cursor[s]) begin
        cursor[s] = '0;
        depth[s]  = '0;
      end
      errors = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_SECTIONS_IN_USE) begin
        sections_in_use = value[SECTIONS_W-1:0];
      end else begin
        slots_per_section = value[SLOTS_W-1:0];
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Applies one accepted operation and queues the result it must produce.
    function void note_op(func_t f, logic [SECTION_W-1:0] sec, logic [SLOT_W-1:0] idx);
      logic [SLOTS_W-1:0] cap;
      bit                 sec_ok;
      slot_result_t       r;
      cap      = (slots_per_section > SLOTS_W'(MAX_SLOTS)) ? SLOTS_W'(MAX_SLOTS)
                                                           : slots_per_section;
      sec_ok   = (int'(sec) < int'(sections_in_use)) && (int'(sec) < MAX_SECTIONS);
      r.slot   = '0;
      r.status = ST_OK;
      case (f)
        FN_ALLOC: begin
          if (!sec_ok) begin
            r.status = ST_INVALID;
          end else if (cursor[sec] < cap) begin
            r.slot      = cursor[sec][SLOT_W-1:0];
            cursor[sec] = cursor[sec] + 1'b1;
          end else if (depth[sec] != '0) begin
            // Linear slots used up: hand back the most recently freed one.
            depth[sec] = depth[sec] - 1'b1;
            r.slot     = freed[sec][depth[sec][SLOT_W-1:0]];
          end else begin
            r.status = ST_FULL;
          end
        end
        FN_FREE: begin
          if (!sec_ok || {1'b0, idx} >= cap) begin
            r.status = ST_INVALID;
          end else if (depth[sec] >= SLOTS_W'(MAX_SLOTS)) begin
            r.status = ST_OVERFLOW;
          end else begin
            freed[sec][depth[sec][SLOT_W-1:0]] = idx;
            depth[sec] = depth[sec] + 1'b1;
          end
        end
        FN_RESET_ONE: begin
          if (!sec_ok) begin
            r.status = ST_INVALID;
          end else begin
            cursor[sec] = '0;
            depth[sec]  = '0;
          end
        end
        default: begin
          // Reset all clears every section regardless of the active count.
          foreach (cursor[s]) begin
            cursor[s] = '0;
            depth[s]  = '0;
          end
        end
      endcase
      owed_results = {owed_results, r};
    endfunction

    // Compares one result beat with the oldest owed result.
    function void check_result(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] status);
      slot_result_t exp_r;
      if (owed_results.size() == 0) begin
        $error("result beat with none owed: slot %0d status %0d", slot, status);
        errors++;
      end else begin
        exp_r = owed_results.pop_front();
        if (slot !== exp_r.slot) begin
          $error("slot: expected %0d, got %0d", exp_r.slot, slot);
          errors++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  slot_scoreboard sb = new();
  bit             long_hold = 1'b0;
  int unsigned    cycle_count = 0;

  // Register settings and operation counts of the random phases.
  int phase_sections [NUM_PHASES] = '{4, 4, 1, 16, 0, 31, 10};
  int phase_slots    [NUM_PHASES] = '{8, 3, 1, 256, 0, 511, 16};
  int phase_ops      [NUM_PHASES] = '{200, 100, 80, 200, 30, 100, 200};
  bit phase_flood    [NUM_PHASES] = '{0, 0, 1, 1, 0, 0, 0};

  sectioned_slot_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Watch both streams; an input beat is noted before a result beat is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_op(func_t'(s_tdata[1:0]), s_tdata[5:2], s_tdata[13:6]);
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata[7:0], m_tdata[9:8]);
      end
    end
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sectioned_slot_allocator test failed");
      $finish;
    end
  end

  // Result side: stretches of steady, random and patterned ready, plus one long hold.
  initial begin : receiver
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((tick / 3) % 2 == 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  // Offers one operation beat and returns at the edge that takes it.
  task automatic send_op(func_t f, logic [SECTION_W-1:0] sec, logic [SLOT_W-1:0] idx);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, idx, sec, f};
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits until every owed result has come back.
  task automatic wait_results();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic write_registers(int sections, int slots);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SECTIONS_IN_USE;
    cfg_data  <= CFG_DATA_W'(sections);
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_SECTIONS_IN_USE, CFG_DATA_W'(sections));
    cfg_index <= CFG_SLOTS_PER_SECTION;
    cfg_data  <= CFG_DATA_W'(slots);
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_SLOTS_PER_SECTION, CFG_DATA_W'(slots));
    cfg_valid <= 1'b0;
  endtask

  // Random operations in bursts with gaps; an optional flood of frees into one
  // section fills its stack to overflow and then allocates from that section.
  task automatic run_phase(int sections, int slots, int n_ops, bit flood);
    int                   cap;
    int                   nsec;
    int                   burst_left;
    int                   pick;
    func_t                f;
    logic [SECTION_W-1:0] sec;
    logic [SLOT_W-1:0]    idx;
    cap        = (slots > MAX_SLOTS) ? MAX_SLOTS : slots;
    nsec       = (sections > MAX_SECTIONS) ? MAX_SECTIONS : sections;
    burst_left = 0;
    for (int i = 0; i < n_ops; i++) begin
      if (burst_left == 0) begin
        pick = $urandom_range(0, 99);
        // A gap drops valid; a burst that follows at once keeps it high.
        if (pick < 75) begin
          s_tvalid <= 1'b0;
          if (pick < 5) begin
            wait_results();
          end else begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        end
        burst_left = $urandom_range(1, 24);
      end
      if (flood && i == n_ops / 2) begin
        send_op(FN_RESET_ONE, '0, 8'($urandom));
        for (int k = 0; k < MAX_SLOTS + 3; k++) begin
          send_op(FN_FREE, '0, SLOT_W'($urandom_range(0, cap - 1)));
        end
        repeat (20) send_op(FN_ALLOC, '0, 8'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        f = FN_ALLOC;
      end else if (pick < 82) begin
        f = FN_FREE;
      end else if (pick < 97) begin
        f = FN_RESET_ONE;
      end else begin
        f = FN_RESET_ALL;
      end
      if (nsec == 0 || $urandom_range(0, 9) == 0) begin
        sec = SECTION_W'($urandom_range(0, 15));
      end else begin
        sec = SECTION_W'($urandom_range(0, nsec - 1));
      end
      if (f == FN_FREE && cap > 0 && $urandom_range(0, 7) != 0) begin
        idx = SLOT_W'($urandom_range(0, cap - 1));
      end else begin
        idx = SLOT_W'($urandom_range(0, 255));
      end
      send_op(f, sec, idx);
      burst_left--;
    end
    s_tvalid <= 1'b0;
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    wait (!rst);
    @(posedge clk);

    // Two sections of two slots: linear, full, pop order and rejected cases.
    write_registers(2, 2);
    send_op(FN_ALLOC, 4'd0, 8'd0);
    send_op(FN_ALLOC, 4'd0, 8'd0);
    send_op(FN_ALLOC, 4'd0, 8'd0);
    send_op(FN_FREE, 4'd0, 8'd1);
    send_op(FN_FREE, 4'd0, 8'd0);
    send_op(FN_ALLOC, 4'd0, 8'd0);
    send_op(FN_ALLOC, 4'd0, 8'd0);
    send_op(FN_ALLOC, 4'd0, 8'd0);
    send_op(FN_FREE, 4'd0, 8'd2);
    send_op(FN_FREE, 4'd2, 8'd0);
    send_op(FN_ALLOC, 4'd15, 8'd0);
    send_op(FN_RESET_ONE, 4'd15, 8'd0);
    send_op(FN_FREE, 4'd1, 8'd255);
    send_op(FN_RESET_ONE, 4'd0, 8'd0);
    send_op(FN_ALLOC, 4'd0, 8'd0);
    send_op(FN_ALLOC, 4'd1, 8'd0);
    send_op(FN_RESET_ALL, 4'd15, 8'd255);
    send_op(FN_ALLOC, 4'd1, 8'd0);
    s_tvalid <= 1'b0;
    wait_results();
    repeat (4) @(posedge clk);

    // Full size: top section and top slot index.
    write_registers(16, 256);
    send_op(FN_ALLOC, 4'd15, 8'd255);
    send_op(FN_FREE, 4'd15, 8'd255);
    send_op(FN_ALLOC, 4'd15, 8'd0);
    send_op(FN_FREE, 4'd15, 8'd128);
    s_tvalid <= 1'b0;
    wait_results();
    repeat (4) @(posedge clk);

    // Random phases; state carries over so lowered capacities meet old cursors.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_registers(phase_sections[p], phase_slots[p]);
      if (p == 3) long_hold = 1'b1;
      run_phase(phase_sections[p], phase_slots[p], phase_ops[p], phase_flood[p]);
    end

    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sectioned_slot_allocator test passed");
    end else begin
      $display("sectioned_slot_allocator test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_ram.sv
hw/rtl/ssa_cfg.sv
hw/rtl/sectioned_slot_allocator.sv
dv/sectioned_slot_allocator_test.sv
